>>> rtl/idwf_pkg.sv
// Shared types, constants and microcode for the I2C display write frame block.
package idwf_pkg;

  localparam logic [7:0] ADDR_RESET   = 8'h78;
  localparam logic [7:0] CTRL_COMMAND = 8'h00;
  localparam logic [7:0] CTRL_DATA    = 8'h40;

  localparam int STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;

  // Program addresses
  localparam step_t STEP_START_HI = 3'd0;
  localparam step_t STEP_START_LO = 3'd1;
  localparam step_t STEP_BIT_HI   = 3'd2;
  localparam step_t STEP_BIT_LO   = 3'd3;
  localparam step_t STEP_ACK      = 3'd4;
  localparam step_t STEP_STOP_LO  = 3'd5;
  localparam step_t STEP_STOP_HI  = 3'd6;
  localparam step_t STEP_IDLE     = 3'd7;

  typedef enum logic [1:0] {
    SDA_ZERO,
    SDA_ONE,
    SDA_BIT,
    SDA_REL
  } sda_sel_t;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_BIT,
    JMP_BYTE,
    JMP_END
  } jmp_t;

  typedef enum logic [1:0] {
    BYTE_ADDR,
    BYTE_CTRL,
    BYTE_PAYLOAD
  } byte_sel_t;

  typedef struct packed {
    sda_sel_t sda_sel;
    logic     scl;
    logic     last;
    logic     load_byte;
    jmp_t     jmp;
    step_t    target;
  } ctrl_t;

  // Control word plus step strobe from sequencer to datapath
  typedef struct packed {
    ctrl_t ctrl;
    logic  step_en;
  } dp_cmd_t;

  // Datapath status back to the sequencer
  typedef struct packed {
    logic out_free;
    logic bit_done;
    logic byte_done;
  } dp_stat_t;

  function automatic ctrl_t idwf_ucode(input step_t step);
    ctrl_t w;
    w = '{sda_sel: SDA_ONE, scl: 1'b1, last: 1'b0, load_byte: 1'b0,
          jmp: JMP_NONE, target: STEP_START_HI};
    case (step)
      STEP_START_HI: w.sda_sel = SDA_ONE;
      STEP_START_LO: begin
        w.sda_sel   = SDA_ZERO;
        w.load_byte = 1'b1;
      end
      STEP_BIT_HI: w.sda_sel = SDA_BIT;
      STEP_BIT_LO: begin
        w.sda_sel = SDA_BIT;
        w.scl     = 1'b0;
        w.jmp     = JMP_BIT;
        w.target  = STEP_BIT_HI;
      end
      STEP_ACK: begin
        w.sda_sel = SDA_REL;
        w.jmp     = JMP_BYTE;
        w.target  = STEP_BIT_HI;
      end
      STEP_STOP_LO: begin
        w.sda_sel = SDA_ZERO;
        w.scl     = 1'b0;
      end
      STEP_STOP_HI: w.sda_sel = SDA_ZERO;
      STEP_IDLE: begin
        w.sda_sel = SDA_ONE;
        w.last    = 1'b1;
        w.jmp     = JMP_END;
      end
      default: w.sda_sel = SDA_ONE;
    endcase
    return w;
  endfunction

endpackage

>>> rtl/idwf_sequencer.sv
// Step counter and microcode lookup with conditional jumps.
module idwf_sequencer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  idwf_pkg::dp_stat_t stat,
  output logic               busy,
  output idwf_pkg::dp_cmd_t  cmd
);
  import idwf_pkg::*;

  logic  busy_r, busy_nxt;
  step_t step_r, step_nxt;
  ctrl_t ctrl;
  logic  step_en;

  assign ctrl    = idwf_ucode(step_r);
  assign step_en = busy_r & stat.out_free;
  assign busy    = busy_r;
  assign cmd     = '{ctrl: ctrl, step_en: step_en};

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_START_HI;
    end else if (step_en) begin
      case (ctrl.jmp)
        JMP_BIT:  step_nxt = stat.bit_done ? step_r + step_t'(1) : ctrl.target;
        JMP_BYTE: step_nxt = stat.byte_done ? step_r + step_t'(1) : ctrl.target;
        JMP_END: begin
          busy_nxt = 1'b0;
          step_nxt = STEP_START_HI;
        end
        default:  step_nxt = step_r + step_t'(1);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= STEP_START_HI;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

endmodule

>>> rtl/idwf_datapath.sv
// Byte registers, bit counter, line level selection and output register.
module idwf_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  logic               in_mode,
  input  logic [7:0]         in_payload,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  input  idwf_pkg::dp_cmd_t  cmd,
  output idwf_pkg::dp_stat_t stat,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_sda_level,
  output logic               out_sda_release,
  output logic               out_scl_level,
  output logic               out_last
);
  import idwf_pkg::*;

  logic [7:0] addr_r;
  logic       mode_r;
  logic [7:0] payload_r;
  byte_sel_t  byte_sel_r, byte_sel_nxt;
  logic [2:0] bit_cnt_r, bit_cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       sda_r, rel_r, scl_r, last_r;
  logic [7:0] cur_byte;
  logic       cur_bit;
  logic       sda_nxt, rel_nxt;

  always_comb begin
    case (byte_sel_r)
      BYTE_ADDR: cur_byte = addr_r;
      BYTE_CTRL: cur_byte = mode_r ? CTRL_DATA : CTRL_COMMAND;
      default:   cur_byte = payload_r;
    endcase
  end

  assign cur_bit = cur_byte[bit_cnt_r];

  always_comb begin
    sda_nxt = 1'b0;
    rel_nxt = 1'b0;
    case (cmd.ctrl.sda_sel)
      SDA_ONE: sda_nxt = 1'b1;
      SDA_BIT: sda_nxt = cur_bit;
      SDA_REL: rel_nxt = 1'b1;
      default: sda_nxt = 1'b0;
    endcase
  end

  always_comb begin
    byte_sel_nxt = byte_sel_r;
    bit_cnt_nxt  = bit_cnt_r;
    if (cmd.step_en) begin
      if (cmd.ctrl.load_byte) begin
        byte_sel_nxt = BYTE_ADDR;
        bit_cnt_nxt  = 3'd7;
      end
      case (cmd.ctrl.jmp)
        JMP_BIT: if (!stat.bit_done) bit_cnt_nxt = bit_cnt_r - 3'd1;
        JMP_BYTE: if (!stat.byte_done) begin
          byte_sel_nxt = (byte_sel_r == BYTE_ADDR) ? BYTE_CTRL : BYTE_PAYLOAD;
          bit_cnt_nxt  = 3'd7;
        end
        default: ;
      endcase
    end
  end

  // hold a beat until taken; a taken beat frees the slot in the same cycle
  assign stat.out_free  = !out_valid_r || out_ready;
  assign stat.bit_done  = (bit_cnt_r == 3'd0);
  assign stat.byte_done = (byte_sel_r == BYTE_PAYLOAD);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.step_en) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r      <= ADDR_RESET;
      out_valid_r <= 1'b0;
      byte_sel_r  <= BYTE_ADDR;
      bit_cnt_r   <= 3'd7;
    end else begin
      if (cfg_we) addr_r <= cfg_wdata;
      out_valid_r <= out_valid_nxt;
      byte_sel_r  <= byte_sel_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mode_r    <= in_mode;
      payload_r <= in_payload;
    end
    if (cmd.step_en) begin
      sda_r  <= sda_nxt;
      rel_r  <= rel_nxt;
      scl_r  <= cmd.ctrl.scl;
      last_r <= cmd.ctrl.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sda_level   = sda_r;
  assign out_sda_release = rel_r;
  assign out_scl_level   = scl_r;
  assign out_last        = last_r;

endmodule

>>> rtl/i2c_display_write_frame_core.sv
// Top level of the I2C display write frame generator.
// Each accepted beat (mode, payload) expands into 56 output beats, one bus phase each:
// start, address byte, control byte (0x00 command / 0x40 data), payload byte, each byte
// MSB first with a released-SDA acknowledge clock, then stop and a final idle phase
// flagged by out_last. An eight-step microcode program with a step counter sets the
// timing: one phase per cycle while the output register is drained; a stalled output
// holds the sequence. in_ready is high only between transactions. cfg_wdata is the
// address byte, write bit included (reset 0x78).
module i2c_display_write_frame_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_mode,
  input  logic [7:0] in_payload,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_sda_level,
  output logic       out_sda_release,
  output logic       out_scl_level,
  output logic       out_last
);
  import idwf_pkg::*;

  logic     busy;
  logic     start;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign in_ready = !busy;
  assign start    = in_valid && in_ready;

  idwf_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  idwf_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (start),
    .in_mode         (in_mode),
    .in_payload      (in_payload),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sda_level   (out_sda_level),
    .out_sda_release (out_sda_release),
    .out_scl_level   (out_scl_level),
    .out_last        (out_last)
  );

  a_start_busy : assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !in_ready)
    else $error("sequencer not busy after accept");

  a_end_frees : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step_en && cmd.ctrl.jmp == JMP_END) |=> (in_ready && out_valid && out_last))
    else $error("idle phase did not close the transaction");

  a_idle_only_last : assert property (@(posedge clk) disable iff (!rst_n)
    (in_ready && out_valid) |-> out_last)
    else $error("pending non-final beat while idle");

  a_release_scl : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_sda_release) |-> (out_scl_level && !out_sda_level))
    else $error("acknowledge phase with wrong line levels");

endmodule
